// ===== rtl/fdfc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdfc_pkg
// Shared types and codes of the frame delay controller: command kinds, run
// modes, notices, output selection and the step control word.
// ----------------------------------------------------------------------------
package fdfc_pkg;

   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   localparam logic [7:0] CAPACITY_RESET = 8'd255;
   localparam logic [8:0] ACTIVE_MAX     = 9'd511;

   typedef enum logic [1:0] {
      MODE_WAITING,
      MODE_BUFFERING,
      MODE_PLAYING,
      MODE_PASSTHROUGH
   } run_mode_type;

   typedef enum logic [1:0] {
      NOTICE_NONE,
      NOTICE_SPEECH,
      NOTICE_QUIET,
      NOTICE_NO_DELAY
   } notice_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_INPUT,
      OUT_RING
   } out_sel_type;

   typedef struct packed {
      logic        push_counts;
      logic        ovf_pop;
      logic        play_pop;
      logic        clear_count;
      out_sel_type out_sel;
      notice_type  notice;
      logic        overflow;
      logic [7:0]  delay_frames;
   } step_ctrl_type;

endpackage

// ===== rtl/fdfc_ring_mem.sv =====
// ----------------------------------------------------------------------------
// fdfc_ring_mem
// Frame ring storage: one write port, two registered read ports with
// write-through when a read hits the entry written in the same cycle.
// ----------------------------------------------------------------------------
module fdfc_ring_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 18,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] ring_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr_a)) begin
            rd_a_ff <= wr_data;
         end else begin
            rd_a_ff <= ring_ff[rd_addr_a];
         end
         if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_b_ff <= wr_data;
         end else begin
            rd_b_ff <= ring_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/fdfc_front.sv =====
// ----------------------------------------------------------------------------
// fdfc_front
// Accept stage: run mode, ring pointers and capacity. Decodes each item into
// ring accesses and a control word for the count stage.
// ----------------------------------------------------------------------------
module fdfc_front #(
   parameter int unsigned DEPTH         = 256,
   parameter int unsigned FRAME_ID_BITS = 16,
   localparam int unsigned PW = $clog2(DEPTH),
   localparam int unsigned EW = FRAME_ID_BITS + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [1:0]                kind,
   input  logic                      enabled,
   input  logic                      frame_valid,
   input  logic                      frame_active,
   input  logic [FRAME_ID_BITS-1:0]  frame_id,
   input  logic                      csr_write_en,
   input  logic [7:0]                csr_write_data,
   output logic                      ring_wr_en,
   output logic [PW-1:0]             ring_wr_addr,
   output logic [EW-1:0]             entry,
   output logic [PW-1:0]             ring_rd_addr_a,
   output logic [PW-1:0]             ring_rd_addr_b,
   output fdfc_pkg::step_ctrl_type   ctrl
);

   import fdfc_pkg::*;

   localparam int unsigned LW   = PW + 1;
   localparam int unsigned LAST = DEPTH - 1;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p,
                                             input logic [PW-1:0] last);
      ptr_inc = (p == last) ? '0 : p + 1'b1;
   endfunction

   run_mode_type     mode_ff;
   run_mode_type     mode_in;
   logic [PW-1:0]    wp_ff;
   logic [PW-1:0]    wp_in;
   logic [PW-1:0]    rp_ff;
   logic [PW-1:0]    rp_in;
   logic [7:0]       cap_ff;

   logic [PW-1:0]    last_slot;
   logic [LW-1:0]    slots;
   logic             counts;
   logic             nonempty;
   logic             push;
   logic             play;
   logic             clear;
   out_sel_type      out_sel;
   notice_type       notice;
   logic [PW-1:0]    wp_inc;
   logic [PW-1:0]    rp_inc;
   logic [PW-1:0]    rp_inc2;
   logic             ovf;
   logic [LW-1:0]    wp_x;
   logic [LW-1:0]    rp_x;
   logic [LW-1:0]    len;

   assign last_slot = (32'(cap_ff) >= 32'(LAST)) ? PW'(LAST) : PW'(cap_ff);
   assign slots     = LW'(last_slot) + 1'b1;

   assign counts   = frame_valid & frame_active;
   assign entry    = {counts, frame_valid, frame_valid ? frame_id : '0};
   assign nonempty = (wp_ff != rp_ff);

   // next mode
   always_comb begin
      mode_in = mode_ff;
      unique case (kind)
         KIND_FRAME: begin
            if (enabled) begin
               if ((mode_ff == MODE_WAITING) && counts) begin
                  mode_in = MODE_BUFFERING;
               end else if ((mode_ff == MODE_PLAYING) && !nonempty) begin
                  mode_in = MODE_PASSTHROUGH;
               end
            end
         end
         KIND_START: mode_in = MODE_PLAYING;
         KIND_STOP:  mode_in = MODE_WAITING;
         default:    mode_in = mode_ff;
      endcase
   end

   // actions of the item
   always_comb begin
      push    = 1'b0;
      play    = 1'b0;
      clear   = 1'b0;
      out_sel = OUT_NONE;
      notice  = NOTICE_NONE;
      if (kind == KIND_STOP) begin
         clear = 1'b1;
      end else if (kind == KIND_FRAME) begin
         if (!enabled) begin
            out_sel = OUT_INPUT;
         end else begin
            unique case (mode_ff)
               MODE_WAITING: begin
                  if (counts) begin
                     push   = 1'b1;
                     notice = NOTICE_SPEECH;
                  end
               end
               MODE_BUFFERING: push = 1'b1;
               MODE_PLAYING: begin
                  if (nonempty) begin
                     push    = 1'b1;
                     play    = 1'b1;
                     out_sel = OUT_RING;
                  end else begin
                     notice  = NOTICE_NO_DELAY;
                     out_sel = OUT_INPUT;
                  end
               end
               MODE_PASSTHROUGH: out_sel = OUT_INPUT;
               default: out_sel = OUT_INPUT;
            endcase
         end
      end
   end

   assign wp_inc  = ptr_inc(wp_ff, last_slot);
   assign rp_inc  = ptr_inc(rp_ff, last_slot);
   assign rp_inc2 = ptr_inc(rp_inc, last_slot);
   assign ovf     = push && (rp_ff == wp_inc);

   always_comb begin
      if (clear) begin
         wp_in = '0;
         rp_in = '0;
      end else begin
         wp_in = push ? wp_inc : wp_ff;
         priority if (play && ovf) begin
            rp_in = rp_inc2;
         end else if (play || ovf) begin
            rp_in = rp_inc;
         end else begin
            rp_in = rp_ff;
         end
      end
   end

   assign wp_x = LW'(wp_in);
   assign rp_x = LW'(rp_in);
   assign len  = (wp_in >= rp_in) ? (wp_x - rp_x) : (wp_x + slots - rp_x);

   assign ctrl.push_counts  = push & counts;
   assign ctrl.ovf_pop      = ovf;
   assign ctrl.play_pop     = play;
   assign ctrl.clear_count  = clear;
   assign ctrl.out_sel      = out_sel;
   assign ctrl.notice       = notice;
   assign ctrl.overflow     = ovf;
   assign ctrl.delay_frames = 8'(len);

   assign ring_wr_en     = accept & push;
   assign ring_wr_addr   = wp_ff;
   assign ring_rd_addr_a = rp_ff;
   assign ring_rd_addr_b = rp_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_WAITING;
         wp_ff   <= '0;
         rp_ff   <= '0;
         cap_ff  <= CAPACITY_RESET;
      end else if (csr_write_en) begin
         cap_ff <= csr_write_data;
         wp_ff  <= '0;
         rp_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
      end
   end

endmodule

// ===== rtl/fdfc_back.sv =====
// ----------------------------------------------------------------------------
// fdfc_back
// Count stage and output register: takes the ring read data, keeps the count
// of active frames held and the quiescence flag, and forms the result item.
// ----------------------------------------------------------------------------
module fdfc_back #(
   parameter int unsigned FRAME_ID_BITS = 16,
   localparam int unsigned EW = FRAME_ID_BITS + 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  fdfc_pkg::step_ctrl_type   ctrl,
   input  logic [EW-1:0]             entry,
   input  logic [EW-1:0]             rd_data_a,
   input  logic [EW-1:0]             rd_data_b,
   input  logic                      csr_write_en,
   input  logic                      rsp_ready,
   output logic                      step_ready,
   output logic                      rsp_valid,
   output logic                      rsp_out_valid,
   output logic                      rsp_out_active,
   output logic [FRAME_ID_BITS-1:0]  rsp_out_frame_id,
   output logic [1:0]                rsp_notice,
   output logic                      rsp_overflow,
   output logic [7:0]                rsp_delay_frames
);

   import fdfc_pkg::*;

   localparam int unsigned VB = FRAME_ID_BITS;
   localparam int unsigned AB = FRAME_ID_BITS + 1;

   logic            s2_valid_ff;
   logic            s2_valid_in;
   step_ctrl_type   s2_ctrl_ff;
   logic [EW-1:0]   s2_entry_ff;
   logic [8:0]      act_ff;
   logic [8:0]      act_in;
   logic            quiet_ff;
   logic            quiet_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [EW-1:0]   rsp_word_ff;
   notice_type      rsp_notice_ff;
   logic            rsp_overflow_ff;
   logic [7:0]      rsp_delay_ff;

   logic            advance;
   logic [EW-1:0]   popped;
   logic [EW-1:0]   out_word;
   notice_type      notice;
   logic [8:0]      act0;
   logic [8:0]      act1;
   logic [8:0]      act2;

   assign advance    = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign step_ready = !s2_valid_ff || !rsp_valid_ff || rsp_ready;

   assign s2_valid_in  = accept | (s2_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   assign popped = s2_ctrl_ff.ovf_pop ? rd_data_b : rd_data_a;

   // active count: clear, push, overflow drop, then play-out
   always_comb begin
      act0 = s2_ctrl_ff.clear_count ? '0 : act_ff;
      act1 = (s2_ctrl_ff.push_counts && (act0 < ACTIVE_MAX)) ? act0 + 1'b1 : act0;
      act2 = (s2_ctrl_ff.ovf_pop && rd_data_a[VB] && rd_data_a[AB] && (act1 != '0))
             ? act1 - 1'b1 : act1;
      act_in = (s2_ctrl_ff.play_pop && popped[VB] && popped[AB] && (act2 != '0))
               ? act2 - 1'b1 : act2;
   end

   always_comb begin
      notice   = s2_ctrl_ff.notice;
      quiet_in = quiet_ff;
      if (s2_ctrl_ff.play_pop) begin
         if (act_in == '0) begin
            if (!quiet_ff) begin
               quiet_in = 1'b1;
               notice   = NOTICE_QUIET;
            end
         end else if (quiet_ff) begin
            quiet_in = 1'b0;
            notice   = NOTICE_SPEECH;
         end
      end
   end

   always_comb begin
      unique case (s2_ctrl_ff.out_sel)
         OUT_INPUT: out_word = s2_entry_ff;
         OUT_RING:  out_word = popped;
         default:   out_word = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         act_ff       <= '0;
         quiet_ff     <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            act_ff <= '0;
         end else if (advance) begin
            act_ff   <= act_in;
            quiet_ff <= quiet_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_ctrl_ff  <= ctrl;
         s2_entry_ff <= entry;
      end
      if (advance) begin
         rsp_word_ff     <= out_word;
         rsp_notice_ff   <= notice;
         rsp_overflow_ff <= s2_ctrl_ff.overflow;
         rsp_delay_ff    <= s2_ctrl_ff.delay_frames;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = rsp_word_ff[VB];
   assign rsp_out_active   = rsp_word_ff[VB] & rsp_word_ff[AB];
   assign rsp_out_frame_id = rsp_word_ff[VB] ? rsp_word_ff[VB-1:0] : '0;
   assign rsp_notice       = rsp_notice_ff;
   assign rsp_overflow     = rsp_overflow_ff;
   assign rsp_delay_frames = rsp_delay_ff;

endmodule

// ===== rtl/frame_delay_fifo_controller.sv =====
// ----------------------------------------------------------------------------
// frame_delay_fifo_controller
// Audio frame delay controller: delays frame handles through a ring with
// speech-driven buffering, playing and passthrough modes.
// ----------------------------------------------------------------------------
// Usage
//   req_*: one item per handshake, a frame handle with its flags or a start
//   or stop command. rsp_*: exactly one result item per request item, in
//   order. csr_write_*: sets the ring capacity and empties the ring; write
//   only while no item is in flight.
//   Path: an item is registered in the count stage, then in the output
//   register. Throughput: one item per cycle while rsp_ready is high. Each
//   item does at most one ring write and two reads on the dual-read ring
//   memory; pointers move on accept, the active count in the count stage.
//   Reset: mode waiting, ring empty, capacity 255, no result pending. The
//   ring memory itself is not cleared; entries are only read once written.
//   Stall: while rsp_ready is low the output register holds its result and
//   one more item can still be accepted into the count stage; after that
//   req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module frame_delay_fifo_controller #(
   parameter int unsigned DEPTH         = 256,
   parameter int unsigned FRAME_ID_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic                      req_enabled,
   input  logic                      req_frame_valid,
   input  logic                      req_frame_active,
   input  logic [FRAME_ID_BITS-1:0]  req_frame_id,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_out_valid,
   output logic                      rsp_out_active,
   output logic [FRAME_ID_BITS-1:0]  rsp_out_frame_id,
   output logic [1:0]                rsp_notice,
   output logic                      rsp_overflow,
   output logic [7:0]                rsp_delay_frames,
   input  logic                      csr_write_en,
   input  logic [7:0]                csr_write_data
);

   import fdfc_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned EW = FRAME_ID_BITS + 2;

   logic            accept;
   logic            step_ready;
   logic            ring_wr_en;
   logic [PW-1:0]   ring_wr_addr;
   logic [EW-1:0]   entry;
   logic [PW-1:0]   ring_rd_addr_a;
   logic [PW-1:0]   ring_rd_addr_b;
   logic [EW-1:0]   rd_data_a;
   logic [EW-1:0]   rd_data_b;
   step_ctrl_type   ctrl;

   assign req_ready = step_ready;
   assign accept    = req_valid & step_ready;

   fdfc_front #(
      .DEPTH         (DEPTH),
      .FRAME_ID_BITS (FRAME_ID_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .kind           (req_kind),
      .enabled        (req_enabled),
      .frame_valid    (req_frame_valid),
      .frame_active   (req_frame_active),
      .frame_id       (req_frame_id),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .ring_wr_en     (ring_wr_en),
      .ring_wr_addr   (ring_wr_addr),
      .entry          (entry),
      .ring_rd_addr_a (ring_rd_addr_a),
      .ring_rd_addr_b (ring_rd_addr_b),
      .ctrl           (ctrl)
   );

   fdfc_ring_mem #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_ring (
      .clock     (clock),
      .wr_en     (ring_wr_en),
      .wr_addr   (ring_wr_addr),
      .wr_data   (entry),
      .rd_en     (accept),
      .rd_addr_a (ring_rd_addr_a),
      .rd_addr_b (ring_rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   fdfc_back #(
      .FRAME_ID_BITS (FRAME_ID_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .ctrl             (ctrl),
      .entry            (entry),
      .rd_data_a        (rd_data_a),
      .rd_data_b        (rd_data_b),
      .csr_write_en     (csr_write_en),
      .rsp_ready        (rsp_ready),
      .step_ready       (step_ready),
      .rsp_valid        (rsp_valid),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_active   (rsp_out_active),
      .rsp_out_frame_id (rsp_out_frame_id),
      .rsp_notice       (rsp_notice),
      .rsp_overflow     (rsp_overflow),
      .rsp_delay_frames (rsp_delay_frames)
   );

`ifndef ASSERT_OFF
   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_no_delay_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_notice == NOTICE_NO_DELAY)) |-> (rsp_delay_frames == 8'd0))
      else $error("no-delay notice with frames held");

   a_empty_frame_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_valid) |-> (!rsp_out_active && (rsp_out_frame_id == '0)))
      else $error("absent frame carries data");
`endif

endmodule

// ===== tb/tb_frame_delay_fifo_controller.sv =====
// ----------------------------------------------------------------------------
// tb_frame_delay_fifo_controller
// Self-checking bench for the frame delay controller. A short table of
// directed items comes first; random speech episodes follow (optional stop,
// buffering, start, play-out) with bursts of noise items mixed in, over
// several ring capacities, both channels idling at random in most phases.
// Each result is matched field by field to the table or a cycle-free model.
// ----------------------------------------------------------------------------
module tb_frame_delay_fifo_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import fdfc_pkg::*;

   localparam int unsigned DEPTH         = 256;
   localparam int unsigned FRAME_ID_BITS = 16;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam logic [1:0]  KIND_UNKNOWN  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic        enabled;
      logic        frame_valid;
      logic        frame_active;
      logic [15:0] frame_id;
   } frame_item_type;

   typedef struct packed {
      logic        out_valid;
      logic        out_active;
      logic [15:0] out_id;
      notice_type  notice;
      logic        overflow;
      logic [7:0]  delay_frames;
   } frame_result_type;

   typedef struct packed {
      logic        valid;
      logic        active;
      logic [15:0] id;
   } ring_entry_type;

   typedef struct packed {
      frame_item_type   item;
      logic             typed;
      frame_result_type want;
   } opening_row_type;

   localparam frame_result_type NO_OUTPUT = '0;

   localparam opening_row_type OPENING_ROWS [21] = '{
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b0, 16'h0000}, 1'b1, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b0, 1'b1, 1'b1, 16'hffff}, 1'b1,
        '{1'b1, 1'b1, 16'hffff, NOTICE_NONE, 1'b0, 8'd0}},
      '{'{KIND_FRAME,   1'b1, 1'b0, 1'b1, 16'h1234}, 1'b1, NO_OUTPUT},
      '{'{KIND_UNKNOWN, 1'b1, 1'b1, 1'b1, 16'h5555}, 1'b1, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b1, 16'h0001}, 1'b1,
        '{1'b0, 1'b0, 16'h0000, NOTICE_SPEECH, 1'b0, 8'd1}},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b0, 16'h0002}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b1, 16'hffff}, 1'b0, NO_OUTPUT},
      '{'{KIND_START,   1'b0, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b0, 16'h0010}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b0, 16'h0011}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b0, 16'h0012}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b0, 16'h0013}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b1, 16'h0014}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b0, 1'b1, 1'b0, 16'h7fff}, 1'b0, NO_OUTPUT},
      '{'{KIND_STOP,    1'b1, 1'b1, 1'b1, 16'hffff}, 1'b1, NO_OUTPUT},
      '{'{KIND_START,   1'b1, 1'b1, 1'b1, 16'hffff}, 1'b1, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b1, 16'habcd}, 1'b1,
        '{1'b1, 1'b1, 16'habcd, NOTICE_NO_DELAY, 1'b0, 8'd0}},
      '{'{KIND_FRAME,   1'b1, 1'b0, 1'b0, 16'h0000}, 1'b0, NO_OUTPUT},
      '{'{KIND_FRAME,   1'b1, 1'b1, 1'b0, 16'h8000}, 1'b0, NO_OUTPUT},
      '{'{KIND_STOP,    1'b0, 1'b0, 1'b0, 16'h0000}, 1'b1, NO_OUTPUT}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_kind = KIND_FRAME;
   logic                     req_enabled = 1'b0;
   logic                     req_frame_valid = 1'b0;
   logic                     req_frame_active = 1'b0;
   logic [FRAME_ID_BITS-1:0] req_frame_id = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_out_valid;
   logic                     rsp_out_active;
   logic [FRAME_ID_BITS-1:0] rsp_out_frame_id;
   logic [1:0]               rsp_notice;
   logic                     rsp_overflow;
   logic [7:0]               rsp_delay_frames;
   logic                     csr_write_en = 1'b0;
   logic [7:0]               csr_write_data = '0;

   // delay ring model state
   logic [7:0]     capacity = CAPACITY_RESET;
   run_mode_type   play_mode = MODE_WAITING;
   logic [7:0]     wr_ptr = '0;
   logic [7:0]     rd_ptr = '0;
   logic [8:0]     speech_count = '0;
   logic           quiet_sent = 1'b0;
   ring_entry_type ring_mem [DEPTH];

   frame_result_type outputs_due [$];
   int unsigned      sender_idle_pct = 0;
   int unsigned      receiver_idle_pct = 0;
   int unsigned      items_sent = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      stall_cycles = 0;

   frame_delay_fifo_controller #(
      .DEPTH         (DEPTH),
      .FRAME_ID_BITS (FRAME_ID_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_enabled      (req_enabled),
      .req_frame_valid  (req_frame_valid),
      .req_frame_active (req_frame_active),
      .req_frame_id     (req_frame_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_active   (rsp_out_active),
      .rsp_out_frame_id (rsp_out_frame_id),
      .rsp_notice       (rsp_notice),
      .rsp_overflow     (rsp_overflow),
      .rsp_delay_frames (rsp_delay_frames),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int ring_slots();
      return int'(capacity) + 1;
   endfunction

   function automatic ring_entry_type ring_take();
      ring_entry_type e;
      e = ring_mem[rd_ptr];
      rd_ptr = (int'(rd_ptr) + 1 >= ring_slots()) ? 8'd0 : rd_ptr + 8'd1;
      if (e.valid && e.active && speech_count != 9'd0) speech_count--;
      return e;
   endfunction

   function automatic logic ring_put(ring_entry_type e);
      if (e.valid && e.active && speech_count != ACTIVE_MAX) speech_count++;
      ring_mem[wr_ptr] = e;
      wr_ptr = (int'(wr_ptr) + 1 >= ring_slots()) ? 8'd0 : wr_ptr + 8'd1;
      if (rd_ptr == wr_ptr) begin
         void'(ring_take());
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic frame_result_type advance_delay_line(frame_item_type it);
      ring_entry_type   entry;
      ring_entry_type   given;
      frame_result_type r;
      entry = '0;
      given = '0;
      r = '0;
      if (it.frame_valid) entry = {1'b1, it.frame_active, it.frame_id};
      case (it.kind)
         KIND_START: begin
            play_mode = MODE_PLAYING;
         end
         KIND_STOP: begin
            play_mode = MODE_WAITING;
            wr_ptr = '0;
            rd_ptr = '0;
            speech_count = '0;
         end
         KIND_FRAME: begin
            if (!it.enabled) begin
               given = entry;
            end else begin
               case (play_mode)
                  MODE_WAITING: begin
                     if (entry.valid && entry.active) begin
                        play_mode = MODE_BUFFERING;
                        r.notice = NOTICE_SPEECH;
                        r.overflow = ring_put(entry);
                     end
                  end
                  MODE_BUFFERING: begin
                     r.overflow = ring_put(entry);
                  end
                  MODE_PLAYING: begin
                     if (wr_ptr != rd_ptr) begin
                        r.overflow = ring_put(entry);
                        given = ring_take();
                        if (speech_count == 9'd0) begin
                           if (!quiet_sent) begin
                              quiet_sent = 1'b1;
                              r.notice = NOTICE_QUIET;
                           end
                        end else if (quiet_sent) begin
                           quiet_sent = 1'b0;
                           r.notice = NOTICE_SPEECH;
                        end
                     end else begin
                        play_mode = MODE_PASSTHROUGH;
                        r.notice = NOTICE_NO_DELAY;
                        given = entry;
                     end
                  end
                  default: begin
                     given = entry;
                  end
               endcase
            end
         end
         default: ;
      endcase
      if (given.valid) begin
         r.out_valid = 1'b1;
         r.out_active = given.active;
         r.out_id = given.id;
      end
      r.delay_frames = 8'((wr_ptr >= rd_ptr) ? int'(wr_ptr) - int'(rd_ptr)
                                             : int'(wr_ptr) + ring_slots() - int'(rd_ptr));
      return r;
   endfunction

   function automatic frame_item_type speech_frame(int unsigned density);
      frame_item_type it;
      it.kind = KIND_FRAME;
      it.enabled = ($urandom_range(0, 9) != 0);
      it.frame_valid = ($urandom_range(0, 9) != 0);
      it.frame_active = ($urandom_range(0, 99) < density);
      it.frame_id = 16'($urandom);
      return it;
   endfunction

   function automatic frame_item_type command_item(logic [1:0] kind);
      frame_item_type it;
      it = {kind, 3'($urandom), 16'($urandom)};
      return it;
   endfunction

   task automatic send_item(frame_item_type it, logic typed, frame_result_type want);
      frame_result_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= it.kind;
      req_enabled <= it.enabled;
      req_frame_valid <= it.frame_valid;
      req_frame_active <= it.frame_active;
      req_frame_id <= it.frame_id;
      do @(posedge clock); while (!req_ready);
      predicted = advance_delay_line(it);
      outputs_due.push_back(typed ? want : predicted);
      if (it.kind != KIND_UNKNOWN) items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic note_failure(string what, frame_result_type want, frame_result_type got);
      if (mismatch_count < 10) begin
         $display("%0t %s: expected valid %b active %b id %h notice %0d ovf %b held %0d",
                  $realtime, what, want.out_valid, want.out_active, want.out_id,
                  want.notice, want.overflow, want.delay_frames);
         $display("%0t %s: actual   valid %b active %b id %h notice %0d ovf %b held %0d",
                  $realtime, what, got.out_valid, got.out_active, got.out_id,
                  got.notice, got.overflow, got.delay_frames);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_valid, rsp_out_active, rsp_out_frame_id, rsp_notice,
                rsp_overflow, rsp_delay_frames};
         if (outputs_due.size() == 0) begin
            note_failure("unexpected item", NO_OUTPUT, got);
         end else begin
            want = outputs_due.pop_front();
            if (got.out_valid !== want.out_valid || got.out_active !== want.out_active ||
                got.out_id !== want.out_id || got.notice !== want.notice ||
                got.overflow !== want.overflow || got.delay_frames !== want.delay_frames) begin
               note_failure("mismatch", want, got);
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_frame_delay_fifo_controller: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [7:0]     phase_caps [8];
      frame_item_type noise;
      int unsigned    phase;
      int unsigned    target;
      int unsigned    halfway;
      int unsigned    density;
      int unsigned    fill;
      int unsigned    drain;
      int unsigned    burst;
      logic           paused;
      logic           big;
      phase_caps = '{8'd255, 8'd0, 8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 254)),
                     8'd128, 8'($urandom_range(1, 255))};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            sender_idle_pct = 18;
            receiver_idle_pct = 85;
         end else if (phase < 6) begin
            sender_idle_pct = 85;
            receiver_idle_pct = 18;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         if (phase == 0) begin
            foreach (OPENING_ROWS[i]) begin
               send_item(OPENING_ROWS[i].item, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
            end
         end else begin
            // capacity change empties the ring, mode is kept
            wait_drained();
            repeat (3) @(posedge clock);
            csr_write_en <= 1'b1;
            csr_write_data <= phase_caps[phase];
            @(posedge clock);
            csr_write_en <= 1'b0;
            capacity = phase_caps[phase];
            wr_ptr = '0;
            rd_ptr = '0;
            speech_count = '0;
         end
         target = items_sent + 165;
         halfway = items_sent + 80;
         paused = 1'b0;
         while (items_sent < target) begin
            if (!paused && items_sent >= halfway) begin
               wait_drained();
               paused = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
               burst = $urandom_range(1, 6);
               repeat (burst) begin
                  noise = {2'($urandom_range(0, 3)), 3'($urandom), 16'($urandom)};
                  send_item(noise, 1'b0, NO_OUTPUT);
               end
            end else begin
               // optional stop, buffer, start, play out
               density = $urandom_range(0, 100);
               big = ($urandom_range(0, 11) == 0);
               fill = big ? int'(capacity) + 3 : $urandom_range(0, 10);
               drain = big ? $urandom_range(0, 16) : $urandom_range(0, fill + 8);
               if ($urandom_range(0, 3) != 0) send_item(command_item(KIND_STOP), 1'b0, NO_OUTPUT);
               repeat (fill) send_item(speech_frame(density), 1'b0, NO_OUTPUT);
               send_item(command_item(KIND_START), 1'b0, NO_OUTPUT);
               repeat (drain) send_item(speech_frame(density), 1'b0, NO_OUTPUT);
            end
         end
      end
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outputs_due.size() == 0) begin
         $display("tb_frame_delay_fifo_controller: clean");
      end else begin
         $display("tb_frame_delay_fifo_controller: errors");
      end
      $finish;
   end

endmodule
